[hw/rtl/assert_macros.svh]
// assertion macros shared by the reply line tag matcher modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define RLTM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// overlapping implication built on the plain form
`define RLTM_ASSERT_IMP(label, ante, cons, msg) \
	`RLTM_ASSERT(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/rltm_pkg.sv]
// shared constants, field widths, result struct and state codes
// for the reply line tag matcher; no dependencies
package rltm_pkg;

	localparam int DEF_BUFFER_SIZE = 64;
	localparam int DEF_NUM_TAGS    = 8;
	localparam int DEF_TAG_LENGTH  = 16;

	localparam int BYTE_W    = 8;
	localparam int SLOT_W    = 3;
	localparam int POS_W     = 4;
	localparam int CFG_W     = 4;
	localparam int LEN_W     = 6;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_O   = 8'h4F;
	localparam logic [BYTE_W-1:0] CHAR_K   = 8'h4B;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TAG  = 1'b1;

	typedef struct packed {
		logic              has_ok;
		logic              tag_match;
		logic [SLOT_W-1:0] slot;
	} srch_res_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_EMIT   = 3'b100
	} ctl_state_t;

	typedef enum logic [4:0] {
		SR_IDLE     = 5'b00001,
		SR_OKSCAN   = 5'b00010,
		SR_TAGLOAD  = 5'b00100,
		SR_LINESCAN = 5'b01000,
		SR_DONE     = 5'b10000
	} srch_state_t;

endpackage

[hw/rtl/rltm_buffers.sv]
// line memory and tag memory, one write and one registered read port each
// depends on rltm_pkg
module rltm_buffers
	import rltm_pkg::*;
#(
	parameter int BUFFER_SIZE = DEF_BUFFER_SIZE,
	parameter int NUM_TAGS    = DEF_NUM_TAGS,
	parameter int TAG_LENGTH  = DEF_TAG_LENGTH,
	localparam int LINE_DEPTH = BUFFER_SIZE - 2,
	localparam int LAW        = $clog2(LINE_DEPTH),
	localparam int TAG_DEPTH  = NUM_TAGS * TAG_LENGTH,
	localparam int TAW        = $clog2(TAG_DEPTH)
) (
	input  logic              clk,
	input  logic              line_we,
	input  logic [LAW-1:0]    line_waddr,
	input  logic [BYTE_W-1:0] line_wdata,
	input  logic [LAW-1:0]    line_raddr,
	output logic [BYTE_W-1:0] line_rdata,
	input  logic              tag_we,
	input  logic [SLOT_W-1:0] tag_slot,
	input  logic [POS_W-1:0]  char_position,
	input  logic [BYTE_W-1:0] tag_wdata,
	input  logic [TAW-1:0]    tag_raddr,
	output logic [BYTE_W-1:0] tag_rdata
);

	logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
	logic [BYTE_W-1:0] tag_mem  [TAG_DEPTH];

	logic             tag_in_range;
	logic [TAW+3:0]   tag_waddr_wide;
	logic [TAW-1:0]   tag_waddr;

	// writes beyond the configured slots or tag length are dropped
	assign tag_in_range   = (int'(tag_slot) < NUM_TAGS) && (int'(char_position) < TAG_LENGTH);
	assign tag_waddr_wide = (TAW+4)'(tag_slot) * (TAW+4)'(TAG_LENGTH) + (TAW+4)'(char_position);
	assign tag_waddr      = tag_waddr_wide[TAW-1:0];

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_waddr] <= line_wdata;
		end
		line_rdata <= line_mem[line_raddr];
	end

	always_ff @(posedge clk) begin
		if (tag_we && tag_in_range) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		tag_rdata <= tag_mem[tag_raddr];
	end

endmodule

[hw/rtl/rltm_search.sv]
// line check sequencer: ok scan, then per slot a tag load and a bit-parallel
// substring scan over the line memory; depends on rltm_pkg and assert_macros.svh
`include "assert_macros.svh"

module rltm_search
	import rltm_pkg::*;
#(
	parameter int BUFFER_SIZE = DEF_BUFFER_SIZE,
	parameter int NUM_TAGS    = DEF_NUM_TAGS,
	parameter int TAG_LENGTH  = DEF_TAG_LENGTH,
	localparam int LINE_DEPTH = BUFFER_SIZE - 2,
	localparam int CW         = $clog2(LINE_DEPTH + 1),
	localparam int LAW        = $clog2(LINE_DEPTH),
	localparam int TAG_DEPTH  = NUM_TAGS * TAG_LENGTH,
	localparam int TAW        = $clog2(TAG_DEPTH),
	localparam int LMW        = $clog2(NUM_TAGS + 1),
	localparam int TIW        = $clog2(TAG_LENGTH),
	localparam int TCW        = $clog2(TAG_LENGTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CW-1:0]     line_len,
	input  logic [LMW-1:0]    tag_limit,
	output logic [LAW-1:0]    line_raddr,
	input  logic [BYTE_W-1:0] line_rdata,
	output logic [TAW-1:0]    tag_raddr,
	input  logic [BYTE_W-1:0] tag_rdata,
	output logic              done,
	output srch_res_t         res
);

	srch_state_t          state_q;
	logic [CW-1:0]        iss_q;
	logic                 rv_s1;
	logic [TCW-1:0]       tiss_q;
	logic [TIW-1:0]       tidx_s1;
	logic [CW-1:0]        eff_q;
	logic                 zero_q;
	logic                 prev_o_q;
	logic                 ok_q;
	logic                 match_q;
	logic [LMW-1:0]       slot_q;
	logic [TAW-1:0]       tbase_q;
	logic [TCW-1:0]       plen_q;
	logic                 plen_ok_q;
	logic [TAG_LENGTH-1:0] bits_q;
	logic [BYTE_W-1:0]    tag_q [TAG_LENGTH];

	logic                 line_issue;
	logic                 tag_issue;
	logic [TAG_LENGTH-1:0] bits_d;
	logic [TCW-1:0]       plen_m1;
	logic                 hit;
	logic [LMW+SLOT_W-1:0] slot_wide;
	logic [LMW-1:0]       slot_next;

	assign line_raddr = iss_q[LAW-1:0];
	assign tag_raddr  = tbase_q + TAW'(tiss_q[TIW-1:0]);

	assign line_issue = ((state_q == SR_OKSCAN) && (iss_q < line_len)) ||
	                    ((state_q == SR_LINESCAN) && (iss_q < eff_q));
	assign tag_issue  = (state_q == SR_TAGLOAD) && (tiss_q < TCW'(TAG_LENGTH));

	// shift-and step: bit j set when the last j+1 line bytes equal tag[0..j]
	always_comb begin
		bits_d[0] = (line_rdata == tag_q[0]);
		for (int j = 1; j < TAG_LENGTH; j++) begin
			bits_d[j] = (line_rdata == tag_q[j]) && bits_q[j-1];
		end
	end

	assign plen_m1   = plen_q - TCW'(1);
	assign hit       = bits_d[plen_m1[TIW-1:0]];
	assign slot_next = slot_q + LMW'(1);

	assign slot_wide     = {{SLOT_W{1'b0}}, slot_q};
	assign done          = (state_q == SR_DONE);
	assign res.has_ok    = ok_q;
	assign res.tag_match = match_q;
	assign res.slot      = match_q ? slot_wide[SLOT_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SR_IDLE;
			iss_q     <= '0;
			rv_s1     <= 1'b0;
			tiss_q    <= '0;
			tidx_s1   <= '0;
			eff_q     <= '0;
			zero_q    <= 1'b0;
			prev_o_q  <= 1'b0;
			ok_q      <= 1'b0;
			match_q   <= 1'b0;
			slot_q    <= '0;
			tbase_q   <= '0;
			plen_q    <= '0;
			plen_ok_q <= 1'b0;
			bits_q    <= '0;
		end else begin
			case (state_q)
				SR_IDLE: begin
					if (start) begin
						iss_q    <= '0;
						rv_s1    <= 1'b0;
						eff_q    <= '0;
						zero_q   <= 1'b0;
						prev_o_q <= 1'b0;
						ok_q     <= 1'b0;
						match_q  <= 1'b0;
						slot_q   <= '0;
						tbase_q  <= '0;
						state_q  <= SR_OKSCAN;
					end
				end
				SR_OKSCAN: begin
					rv_s1 <= line_issue;
					if (line_issue) begin
						iss_q <= iss_q + CW'(1);
					end
					// bytes after the first zero are outside the search
					if (rv_s1 && !zero_q) begin
						if (line_rdata == CHAR_NUL) begin
							zero_q <= 1'b1;
						end else begin
							eff_q    <= eff_q + CW'(1);
							prev_o_q <= (line_rdata == CHAR_O);
							if (prev_o_q && (line_rdata == CHAR_K)) begin
								ok_q <= 1'b1;
							end
						end
					end
					if (!line_issue && !rv_s1) begin
						if (ok_q || (tag_limit == '0)) begin
							state_q <= SR_DONE;
						end else begin
							tiss_q    <= '0;
							plen_q    <= TCW'(TAG_LENGTH);
							plen_ok_q <= 1'b0;
							state_q   <= SR_TAGLOAD;
						end
					end
				end
				SR_TAGLOAD: begin
					rv_s1   <= tag_issue;
					tidx_s1 <= tiss_q[TIW-1:0];
					if (tag_issue) begin
						tiss_q <= tiss_q + TCW'(1);
					end
					if (rv_s1 && (tag_rdata == CHAR_NUL) && !plen_ok_q) begin
						plen_q    <= TCW'(tidx_s1);
						plen_ok_q <= 1'b1;
					end
					if (!tag_issue && !rv_s1) begin
						if (plen_q == '0) begin
							// empty tag matches any line
							match_q <= 1'b1;
							state_q <= SR_DONE;
						end else begin
							iss_q   <= '0;
							bits_q  <= '0;
							state_q <= SR_LINESCAN;
						end
					end
				end
				SR_LINESCAN: begin
					if (line_issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (rv_s1) begin
						bits_q <= bits_d;
					end
					if (rv_s1 && hit) begin
						match_q <= 1'b1;
						rv_s1   <= 1'b0;
						state_q <= SR_DONE;
					end else begin
						rv_s1 <= line_issue;
						if (!line_issue && !rv_s1) begin
							if (slot_next < tag_limit) begin
								slot_q    <= slot_next;
								tbase_q   <= tbase_q + TAW'(TAG_LENGTH);
								tiss_q    <= '0;
								plen_q    <= TCW'(TAG_LENGTH);
								plen_ok_q <= 1'b0;
								state_q   <= SR_TAGLOAD;
							end else begin
								state_q <= SR_DONE;
							end
						end
					end
				end
				SR_DONE: begin
					state_q <= SR_IDLE;
				end
				default: begin
					state_q <= SR_IDLE;
				end
			endcase
		end
	end

	// tag characters of the slot under test
	always_ff @(posedge clk) begin
		if ((state_q == SR_TAGLOAD) && rv_s1) begin
			tag_q[tidx_s1] <= tag_rdata;
		end
	end

	`RLTM_ASSERT_IMP(a_res_exclusive, done, !(res.has_ok && res.tag_match), "ok and tag match both set")
	`RLTM_ASSERT_IMP(a_scan_has_tag, state_q == SR_LINESCAN, plen_q != '0, "line scan with empty tag")

endmodule

[hw/rtl/reply_line_tag_matcher.sv]
// reply line tag matcher top level: stream handshakes, line count, sticky flags,
// tag slot register and result register; depends on rltm_pkg, rltm_buffers,
// rltm_search and assert_macros.svh
//
// channel   dir  beat when             payload
// s_*       in   s_tvalid & s_tready   tuser kind, tdata byte/slot/char position
// m_*       out  m_tvalid & m_tready   tuser purged, tdata line result
// cfg_*     in   cfg_valid & cfg_ready cfg_data tags_in_use
//
// a received byte or a tag character leaves the input ready for the next beat; a purge
// beat passes through the emit state; a terminator runs the check: an ok scan over the line,
// then per checked slot a load of the tag and a scan of the line up to its first zero;
// one read port per memory paces it at one byte per cycle
// input stalls during a check and in the cycle a result moves to the output
// register, longer while that register is full; reset clears counters and flags
`include "assert_macros.svh"

module reply_line_tag_matcher
	import rltm_pkg::*;
#(
	parameter int BUFFER_SIZE = DEF_BUFFER_SIZE,
	parameter int NUM_TAGS    = DEF_NUM_TAGS,
	parameter int TAG_LENGTH  = DEF_TAG_LENGTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [7:0] byte_value, [10:8] tag_slot, [14:11] char_position, [15] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] kind
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] line_has_ok, [1] line_tag_match, [4:2] matched_slot, [5] ok_seen,
	// [6] tag_seen, [12:7] line_length, [15:13] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// [0] purged
	output logic                 m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int LINE_DEPTH = BUFFER_SIZE - 2;
	localparam int CW         = $clog2(LINE_DEPTH + 1);
	localparam int LAW        = $clog2(LINE_DEPTH);
	localparam int TAW        = $clog2(NUM_TAGS * TAG_LENGTH);
	localparam int LMW        = $clog2(NUM_TAGS + 1);

	// input beat fields
	logic              kind;
	logic [BYTE_W-1:0] byte_value;
	logic [SLOT_W-1:0] tag_slot;
	logic [POS_W-1:0]  char_position;

	ctl_state_t        state_q;
	logic [CW-1:0]     count_q;
	logic [CFG_W-1:0]  tags_in_use_q;
	logic              ok_q;
	logic              tagf_q;

	// result waiting for the output register
	logic              pend_ok_q;
	logic              pend_match_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic              pend_purge_q;
	logic [LEN_W-1:0]  pend_len_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	logic              s_beat;
	logic              byte_beat;
	logic              is_term;
	logic              line_full;
	logic              line_we;
	logic              tag_we;
	logic              srch_start;
	logic              srch_done;
	srch_res_t         srch_res;
	logic              out_free;

	logic [CW+LEN_W-1:0]    len_wide;
	logic [LMW+CFG_W-1:0]   tiu_wide;
	logic [LMW-1:0]         tag_limit;

	logic [LAW-1:0]    line_raddr;
	logic [BYTE_W-1:0] line_rdata;
	logic [TAW-1:0]    tag_raddr;
	logic [BYTE_W-1:0] tag_rdata;

	assign kind          = s_tuser;
	assign byte_value    = s_tdata[7:0];
	assign tag_slot      = s_tdata[10:8];
	assign char_position = s_tdata[14:11];

	// one item at a time; a running check or a waiting result holds the input off
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_beat    = s_tvalid && s_tready;
	assign byte_beat = s_beat && (kind == KIND_BYTE);
	assign tag_we    = s_beat && (kind == KIND_TAG);

	assign is_term    = (byte_value == CHAR_LF) || (byte_value == CHAR_CR);
	assign line_full  = (count_q == CW'(LINE_DEPTH));
	assign line_we    = byte_beat && !line_full && !is_term;
	assign srch_start = byte_beat && !line_full && is_term;

	assign len_wide = {{LEN_W{1'b0}}, count_q};

	// slot count above the table size is clamped
	assign tiu_wide  = {{LMW{1'b0}}, tags_in_use_q};
	assign tag_limit = (tiu_wide > (LMW+CFG_W)'(NUM_TAGS)) ? LMW'(NUM_TAGS) : tiu_wide[LMW-1:0];

	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	rltm_buffers #(
		.BUFFER_SIZE (BUFFER_SIZE),
		.NUM_TAGS    (NUM_TAGS),
		.TAG_LENGTH  (TAG_LENGTH)
	) u_buffers (
		.clk           (clk),
		.line_we       (line_we),
		.line_waddr    (count_q[LAW-1:0]),
		.line_wdata    (byte_value),
		.line_raddr    (line_raddr),
		.line_rdata    (line_rdata),
		.tag_we        (tag_we),
		.tag_slot      (tag_slot),
		.char_position (char_position),
		.tag_wdata     (byte_value),
		.tag_raddr     (tag_raddr),
		.tag_rdata     (tag_rdata)
	);

	rltm_search #(
		.BUFFER_SIZE (BUFFER_SIZE),
		.NUM_TAGS    (NUM_TAGS),
		.TAG_LENGTH  (TAG_LENGTH)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (srch_start),
		.line_len   (count_q),
		.tag_limit  (tag_limit),
		.line_raddr (line_raddr),
		.line_rdata (line_rdata),
		.tag_raddr  (tag_raddr),
		.tag_rdata  (tag_rdata),
		.done       (srch_done),
		.res        (srch_res)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tags_in_use_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tags_in_use_q <= cfg_data;
		end
	end

	// control: line fill, purge, check hand-off, result emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ok_q         <= 1'b0;
			tagf_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			pend_ok_q    <= 1'b0;
			pend_match_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_purge_q <= 1'b0;
			pend_len_q   <= '0;
		end else begin
			// output register: loaded from the pending result, freed by a taken beat
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (byte_beat) begin
						if (line_full) begin
							// overflow: drop the line and this byte, no check
							pend_ok_q    <= 1'b0;
							pend_match_q <= 1'b0;
							pend_slot_q  <= '0;
							pend_purge_q <= 1'b1;
							pend_len_q   <= len_wide[LEN_W-1:0];
							count_q      <= '0;
							state_q      <= ST_EMIT;
						end else if (is_term) begin
							pend_purge_q <= 1'b0;
							pend_len_q   <= len_wide[LEN_W-1:0];
							state_q      <= ST_SEARCH;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_SEARCH: begin
					if (srch_done) begin
						pend_ok_q    <= srch_res.has_ok;
						pend_match_q <= srch_res.tag_match;
						pend_slot_q  <= srch_res.slot;
						ok_q         <= ok_q | srch_res.has_ok;
						tagf_q       <= tagf_q | srch_res.tag_match;
						count_q      <= '0;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output payload, loaded with the flags as they stand after this line
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= {3'b000, pend_len_q, tagf_q, ok_q, pend_slot_q,
			              pend_match_q, pend_ok_q};
			m_tuser_q <= pend_purge_q;
		end
	end

	`RLTM_ASSERT(a_count_range, count_q <= CW'(LINE_DEPTH), "line count past buffer depth")
	`RLTM_ASSERT(a_ok_sticky, ok_q |=> ok_q, "ok flag cleared")
	`RLTM_ASSERT_IMP(a_purge_clean, m_tvalid && m_tuser, m_tdata[1:0] == 2'b00, "purged beat with check result")
	`RLTM_ASSERT_IMP(a_done_in_search, srch_done, state_q == ST_SEARCH, "check finished outside search")

endmodule

[bench/reply_line_tag_matcher_tb.sv]
// self-checking bench for the reply line tag matcher: drives byte and tag beats,
// checks every line result against an in-bench line/tag predictor
// depends on rltm_pkg and the reply_line_tag_matcher rtl only
module reply_line_tag_matcher_tb
	import rltm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH     = DEF_BUFFER_SIZE - 2;
	localparam int N_TAGS         = DEF_NUM_TAGS;
	localparam int TAG_LEN        = DEF_TAG_LENGTH;
	// cycles left for a byte or purge still in the block after the last result
	localparam int SETTLE         = 64;
	// long receiver hold-off, and the quiet-cycle limit of the watchdog
	localparam int RX_HOLD_CYCLES = 600;
	localparam int STALL_LIMIT    = 5000;
	localparam int PHASE_ITEMS    = 200;

	// one beat on the input stream: a received byte or one tag character
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] value;
		logic [SLOT_W-1:0] tag_slot;
		logic [POS_W-1:0]  char_pos;
	} stream_item_t;

	// one line result as the block reports it
	typedef struct packed {
		logic              has_ok;
		logic              tag_match;
		logic [SLOT_W-1:0] slot;
		logic              ok_seen;
		logic              tag_seen;
		logic              purged;
		logic [LEN_W-1:0]  line_len;
	} line_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// beats waiting for the driver, and line results waiting for the monitor
	stream_item_t rx_stream [$];
	line_result_t line_result_q [$];
	int queued_cnt   = 0;
	int accepted_cnt = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	// predictor state: line buffer, tag memory, sticky flags, register copy
	logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
	int                line_cnt   = 0;
	logic [BYTE_W-1:0] tag_mem [N_TAGS][TAG_LEN];
	logic              ok_sticky  = 1'b0;
	logic              tag_sticky = 1'b0;
	logic [CFG_W-1:0]  tags_cfg   = '0;

	// stimulus-side mirror of the tag memory, used to keep every checked tag
	// fully written and to plant tags inside lines
	logic [BYTE_W-1:0] gen_tag [N_TAGS][TAG_LEN];
	bit                gen_written [N_TAGS][TAG_LEN];

	// driver and monitor side state
	stream_item_t tx_cur;
	int           tx_gap     = 0;
	bit           tx_burst   = 1'b0;
	int           stall_left = 0;
	bit           out_burst  = 1'b0;
	logic         rx_hold    = 1'b0;
	line_result_t want;

	reply_line_tag_matcher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------------
	// line predictor
	// ---------------------------------------------------------------------

	// does the pattern (low byte first) occur in the first eff bytes of the line
	function automatic bit line_holds(input logic [TAG_LEN*8-1:0] pat, input int plen,
		input int eff);
		int i, j;
		bit hit;
		if (plen == 0)
			return 1'b1;
		for (i = 0; i + plen <= eff; i++) begin
			hit = 1'b1;
			for (j = 0; j < plen; j++)
				if (line_mem[i+j] != pat[j*8 +: 8])
					hit = 1'b0;
			if (hit)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// apply one accepted beat to the predictor; a line end or purge queues a result
	function automatic void predict_line_result(input stream_item_t it);
		line_result_t res;
		logic [TAG_LEN*8-1:0] pat;
		int eff, lim, s, p, tlen;
		bit done;
		if (it.kind == KIND_TAG) begin
			tag_mem[it.tag_slot][it.char_pos] = it.value;
			return;
		end
		res = '0;
		res.line_len = line_cnt[LEN_W-1:0];
		if (line_cnt >= LINE_DEPTH) begin
			// full line: dropped unchecked, the byte goes with it
			res.purged = 1'b1;
		end else if (it.value == CHAR_LF || it.value == CHAR_CR) begin
			// search sees only the bytes before an embedded zero
			eff = 0;
			while (eff < line_cnt && line_mem[eff] != CHAR_NUL)
				eff++;
			pat = '0;
			pat[7:0]  = CHAR_O;
			pat[15:8] = CHAR_K;
			if (line_holds(pat, 2, eff)) begin
				res.has_ok = 1'b1;
				ok_sticky  = 1'b1;
			end else begin
				lim  = (tags_cfg > N_TAGS) ? N_TAGS : int'(tags_cfg);
				done = 1'b0;
				for (s = 0; s < lim && !done; s++) begin
					tlen = 0;
					while (tlen < TAG_LEN && tag_mem[s][tlen] != CHAR_NUL)
						tlen++;
					pat = '0;
					for (p = 0; p < tlen; p++)
						pat[p*8 +: 8] = tag_mem[s][p];
					if (line_holds(pat, tlen, eff)) begin
						res.tag_match = 1'b1;
						res.slot      = s[SLOT_W-1:0];
						tag_sticky    = 1'b1;
						done          = 1'b1;
					end
				end
			end
		end else begin
			line_mem[line_cnt] = it.value;
			line_cnt++;
			return;
		end
		line_cnt     = 0;
		res.ok_seen  = ok_sticky;
		res.tag_seen = tag_sticky;
		line_result_q.push_back(res);
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	// mostly short gaps, a few long ones, none at all in a burst stretch
	function automatic int gap_len(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// line text: a small alphabet so tags and "OK" turn up, plus any other byte but zero, LF and CR
	function automatic logic [BYTE_W-1:0] text_char();
		logic [BYTE_W-1:0] c;
		if ($urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 4))
				0: c = CHAR_O;
				1: c = CHAR_K;
				2: c = 8'h41;
				3: c = 8'h42;
				default: c = 8'h78;
			endcase
		end else begin
			do
				c = 8'($urandom_range(1, 255));
			while (c == CHAR_LF || c == CHAR_CR);
		end
		return c;
	endfunction

	// a slot is safe to check when every character up to its end was written
	function automatic bit tag_readable(input int s);
		int p;
		for (p = 0; p < TAG_LEN; p++) begin
			if (!gen_written[s][p])
				return 1'b0;
			if (gen_tag[s][p] == CHAR_NUL)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic int gen_tag_len(input int s);
		int n;
		n = 0;
		while (n < TAG_LEN && gen_tag[s][n] != CHAR_NUL)
			n++;
		return n;
	endfunction

	task automatic put_byte(input logic [BYTE_W-1:0] b);
		stream_item_t it;
		it          = '0;
		it.kind     = KIND_BYTE;
		it.value    = b;
		rx_stream.push_back(it);
		queued_cnt++;
	endtask

	task automatic put_text(input string txt);
		int i;
		for (i = 0; i < txt.len(); i++)
			put_byte(txt[i]);
	endtask

	// a write that would stretch a checkable tag onto unwritten characters
	// is turned into a terminator
	task automatic put_tag_char(input int s, input int p, input logic [BYTE_W-1:0] v);
		stream_item_t it;
		bit was_ok;
		was_ok            = tag_readable(s);
		gen_tag[s][p]     = v;
		gen_written[s][p] = 1'b1;
		if (was_ok && !tag_readable(s)) begin
			v             = CHAR_NUL;
			gen_tag[s][p] = v;
		end
		it          = '0;
		it.kind     = KIND_TAG;
		it.value    = v;
		it.tag_slot = s[SLOT_W-1:0];
		it.char_pos = p[POS_W-1:0];
		rx_stream.push_back(it);
		queued_cnt++;
	endtask

	// whole tag, terminator first and then backward, so the slot stays
	// checkable between any two of its beats
	task automatic load_tag(input int s);
		int r, n, p;
		logic [BYTE_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 5)
			n = 0;
		else if (r < 15)
			n = TAG_LEN;
		else if (r < 25)
			n = $urandom_range(5, TAG_LEN - 1);
		else
			n = $urandom_range(1, 4);
		if (n < TAG_LEN)
			put_tag_char(s, n, CHAR_NUL);
		for (p = n - 1; p >= 0; p--) begin
			c = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : text_char();
			put_tag_char(s, p, c);
		end
	endtask

	task automatic ensure_tags(input int lim);
		int s;
		for (s = 0; s < lim; s++)
			if (!tag_readable(s))
				load_tag(s);
	endtask

	// one line: random text with an occasional planted tag, "OK" or zero byte,
	// stray tag writes in between, then LF or CR
	task automatic queue_line();
		logic [BYTE_W-1:0] txt [LINE_DEPTH];
		int r, n, i, s, tlen, off;
		r = $urandom_range(0, 99);
		if (r < 65)
			n = $urandom_range(0, 6);
		else if (r < 88)
			n = $urandom_range(7, 24);
		else if (r < 97)
			n = $urandom_range(25, LINE_DEPTH - 2);
		else
			n = LINE_DEPTH - 1;
		for (i = 0; i < n; i++)
			txt[i] = text_char();
		if ($urandom_range(0, 2) == 0) begin
			s = $urandom_range(0, N_TAGS - 1);
			if (tag_readable(s)) begin
				tlen = gen_tag_len(s);
				if (tlen <= n) begin
					off = $urandom_range(0, n - tlen);
					for (i = 0; i < tlen; i++)
						txt[off+i] = gen_tag[s][i];
				end
			end
		end
		if ($urandom_range(0, 6) == 0 && n >= 2) begin
			off         = $urandom_range(0, n - 2);
			txt[off]    = CHAR_O;
			txt[off+1]  = CHAR_K;
		end
		if ($urandom_range(0, 11) == 0 && n >= 1)
			txt[$urandom_range(0, n - 1)] = CHAR_NUL;
		for (i = 0; i < n; i++) begin
			put_byte(txt[i]);
			if ($urandom_range(0, 19) == 0)
				put_tag_char($urandom_range(0, N_TAGS - 1), $urandom_range(0, TAG_LEN - 1),
					text_char());
		end
		put_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
	endtask

	// sender pause: everything sent, every result back, then let the block settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (accepted_cnt != queued_cnt || line_result_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_tags_in_use(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tags_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	// one register setting followed by a stretch of random traffic
	task automatic run_phase(input logic [CFG_W-1:0] v);
		int start, r, k;
		ensure_tags((v > N_TAGS) ? N_TAGS : int'(v));
		wait_idle();
		write_tags_in_use(v);
		start = queued_cnt;
		while (queued_cnt - start < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				queue_line();
			end else if (r < 82) begin
				load_tag($urandom_range(0, N_TAGS - 1));
			end else if (r < 91) begin
				// loose tag writes: shorten, overwrite or touch characters past the end
				for (k = $urandom_range(1, 4); k > 0; k--)
					put_tag_char($urandom_range(0, N_TAGS - 1), $urandom_range(0, TAG_LEN - 1),
						($urandom_range(0, 9) == 0) ? CHAR_NUL : text_char());
			end else if (r < 97) begin
				// noise: any byte at all, terminators and zeros included
				for (k = $urandom_range(1, 4); k > 0; k--)
					put_byte(8'($urandom_range(0, 255)));
			end else begin
				// overflow: fill the line, the next byte purges it
				for (k = 0; k < LINE_DEPTH; k++)
					put_byte(text_char());
				put_byte($urandom_range(0, 1) ? CHAR_LF : 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// input driver: one beat at a time from rx_stream, random gaps between beats
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_line_result(tx_cur);
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (rx_stream.size() != 0) begin
					tx_cur = rx_stream.pop_front();
					s_tdata  <= {1'b0, tx_cur.char_pos, tx_cur.tag_slot, tx_cur.value};
					s_tuser  <= tx_cur.kind;
					s_tvalid <= 1'b1;
					tx_gap = gap_len(tx_burst);
					if ($urandom_range(0, 149) == 0)
						tx_burst = !tx_burst;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// result monitor: compares each result beat with the oldest prediction
	// ---------------------------------------------------------------------
	task automatic check_field(input string what, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("line result %0d: %s expected %0d, got %0d",
					results_seen, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (line_result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("line result %0d: unexpected beat tdata %h tuser %b",
							results_seen, m_tdata, m_tuser);
				end else begin
					want = line_result_q.pop_front();
					check_field("line_has_ok", want.has_ok, m_tdata[0]);
					check_field("line_tag_match", want.tag_match, m_tdata[1]);
					check_field("matched_slot", want.slot, m_tdata[4:2]);
					check_field("ok_seen", want.ok_seen, m_tdata[5]);
					check_field("tag_seen", want.tag_seen, m_tdata[6]);
					check_field("line_length", want.line_len, m_tdata[12:7]);
					check_field("purged", want.purged, m_tuser);
				end
				results_seen++;
			end
			// ready: held low during the long hold-off, else random stalls
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!out_burst && $urandom_range(0, 3) == 0)
					stall_left = gap_len(1'b0);
				if ($urandom_range(0, 299) == 0)
					out_burst = !out_burst;
			end
		end
	end

	// long receiver hold-off once traffic is going, so results back up and the
	// block stalls its input while the driver keeps offering beats
	initial begin
		wait (accepted_cnt >= 500);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// watchdog: too many cycles without any beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [CFG_W-1:0] plan [8];
		int k;
		plan[0] = 4'd8;
		plan[1] = 4'd15;
		plan[2] = 4'd3;
		plan[3] = 4'd1;
		plan[4] = 4'd0;
		plan[5] = 4'd8;
		plan[6] = CFG_W'($urandom_range(0, 15));
		plan[7] = CFG_W'($urandom_range(2, 8));
		wait (arst_n);
		@(posedge clk);

		// no tags in use: empty line, "OK" found, "OK" hidden behind a zero byte,
		// top byte value
		put_byte(CHAR_LF);
		put_text("xOK");
		put_byte(CHAR_CR);
		put_text("A");
		put_byte(CHAR_NUL);
		put_text("OK");
		put_byte(CHAR_LF);
		put_byte(8'hFF);
		put_byte(CHAR_LF);
		wait_idle();

		// slot 0 holds "AB", slot 1 the empty tag that matches any line
		put_tag_char(0, 2, CHAR_NUL);
		put_tag_char(0, 1, 8'h42);
		put_tag_char(0, 0, 8'h41);
		put_tag_char(1, 0, CHAR_NUL);
		wait_idle();
		write_tags_in_use(4'd2);
		put_text("xAB");
		put_byte(CHAR_LF);
		put_text("Q");
		put_byte(CHAR_CR);
		// "OK" wins over a tag in the same line
		put_text("OKAB");
		put_byte(CHAR_LF);

		for (k = 0; k < 8; k++)
			run_phase(plan[k]);

		wait_idle();
		if (mismatches == 0 && line_result_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rltm_pkg.sv
hw/rtl/rltm_buffers.sv
hw/rtl/rltm_search.sv
hw/rtl/reply_line_tag_matcher.sv
bench/reply_line_tag_matcher_tb.sv
